/* hw/rtl/dopq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drop-oldest packet queue package
// Shared types, codes and defaults of the drop-oldest packet queue.
// ----------------------------------------------------------------------------
package dopq_pkg;

  localparam int SlotsDefault    = 8;
  localparam int MaxBytesDefault = 4096;

  localparam int LimitW  = 13;
  localparam int QueuedW = 4;
  localparam int StampW  = 64;

  localparam logic [LimitW-1:0] LimitReset = 13'd4096;

  // Register indexes of the configuration port.
  localparam logic RegPacketLimit = 1'b0;

  typedef enum logic {
    CmdPush = 1'b0,
    CmdPop  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    StsByteTaken  = 3'd0,
    StsCommitted  = 3'd1,
    StsCommitDrop = 3'd2,
    StsTooLong    = 3'd3,
    StsPopped     = 3'd4,
    StsEmpty      = 3'd5
  } status_e;

  typedef enum logic {
    StIdle,
    StPopRead
  } state_e;

  typedef struct packed {
    cmd_e              command;
    logic [7:0]        data_byte;
    logic              last_byte;
    logic [StampW-1:0] stamp;
    logic              key_frame;
  } cmd_t;

  typedef struct packed {
    status_e            status;
    logic [7:0]         out_byte;
    logic               out_last;
    logic [StampW-1:0]  out_stamp;
    logic               out_key;
    logic [QueuedW-1:0] queued;
  } rsp_t;

endpackage

/* hw/rtl/drop_oldest_packet_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drop-oldest packet queue
// Byte-wise packet queue with per-packet timestamp and keyframe flag that
// drops the oldest packet when a new one is committed to a full queue.
// ----------------------------------------------------------------------------
// Usage:
// An item is a transfer on start/cmd_i, taken when start is high and busy is
// low. Each item produces exactly one result on rsp_o, marked by done_o for
// a single cycle; the receiver has no way to hold it off.
// A push writes its byte into the byte memory at the accepting edge, and the
// result appears in the next cycle, so pushes can be issued back to back. A
// pop of a queued byte passes through a read state because the byte and slot
// memories have registered reads: busy is high for one cycle and the result
// appears in the cycle after that. A pop on an empty queue answers in the next
// cycle.
// The user writes packet_limit over the APB port at address 0 only while the
// queue is idle; the block does not enforce this. pready is always high.
// Reset empties the queue and restores the limit to 4096. The memories need
// no clearing pass, since only bytes of committed packets are ever read.
// ----------------------------------------------------------------------------
module drop_oldest_packet_queue #(
  parameter int SLOTS     = dopq_pkg::SlotsDefault,
  parameter int MAX_BYTES = dopq_pkg::MaxBytesDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  dopq_pkg::cmd_t       cmd_i,
  output logic                 done_o,
  output dopq_pkg::rsp_t       rsp_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int PhysSlots = SLOTS + 1;
  localparam int SlotW     = $clog2(PhysSlots);
  localparam int CntW      = $clog2(SLOTS + 1);
  localparam int OffW      = $clog2(MAX_BYTES + 1);
  localparam int RdW       = $clog2(MAX_BYTES);
  localparam int AddrW     = $clog2(PhysSlots * MAX_BYTES);
  localparam int CmpW      = (OffW > dopq_pkg::LimitW) ? OffW : dopq_pkg::LimitW;
  localparam int StampW    = dopq_pkg::StampW;

  // Configuration register.
  logic [dopq_pkg::LimitW-1:0] packet_limit_q;
  logic                        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == dopq_pkg::RegPacketLimit);
  assign prdata = (paddr[2] == dopq_pkg::RegPacketLimit) ? 32'(packet_limit_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      packet_limit_q <= dopq_pkg::LimitReset;
    end else if (cfg_we) begin
      packet_limit_q <= pwdata[dopq_pkg::LimitW-1:0];
    end
  end

  // Control state.
  dopq_pkg::state_e state_q, state_d;
  logic [SlotW-1:0] head_q, head_d;
  logic [SlotW-1:0] tail_q, tail_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [OffW-1:0]  wr_off_q, wr_off_d;
  logic [RdW-1:0]   rd_off_q, rd_off_d;
  logic             overlong_q, overlong_d;
  logic             done_q, done_d;
  dopq_pkg::rsp_t   rsp_q, rsp_d;

  // Memory ports.
  logic             byte_we, byte_re;
  logic [AddrW-1:0] byte_addr;
  logic [7:0]       byte_rdata_q;
  logic             meta_we, meta_re;
  logic [SlotW-1:0] meta_addr;
  logic [OffW-1:0]  meta_len_rdata_q;
  logic [StampW-1:0] meta_stamp_rdata_q;
  logic             meta_key_rdata_q;

  logic [7:0]        byte_mem   [PhysSlots * MAX_BYTES];
  logic [OffW-1:0]   meta_len   [PhysSlots];
  logic [StampW-1:0] meta_stamp [PhysSlots];
  logic              meta_key   [PhysSlots];

  always_ff @(posedge clk_i) begin
    if (byte_we) begin
      byte_mem[byte_addr] <= cmd_i.data_byte;
    end
    if (byte_re) begin
      byte_rdata_q <= byte_mem[byte_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (meta_we) begin
      meta_len[meta_addr]   <= wr_off_q + OffW'(1);
      meta_stamp[meta_addr] <= cmd_i.stamp;
      meta_key[meta_addr]   <= cmd_i.key_frame;
    end
    if (meta_re) begin
      meta_len_rdata_q   <= meta_len[meta_addr];
      meta_stamp_rdata_q <= meta_stamp[meta_addr];
      meta_key_rdata_q   <= meta_key[meta_addr];
    end
  end

  function automatic logic [SlotW-1:0] next_slot(input logic [SlotW-1:0] s);
    return (s == SlotW'(PhysSlots - 1)) ? '0 : s + SlotW'(1);
  endfunction

  logic             accept;
  logic [CmpW-1:0]  limit_eff;
  logic             at_limit;
  logic             queue_full;
  logic             pop_last;

  assign accept     = start && !busy;
  assign limit_eff  = (CmpW'(packet_limit_q) > CmpW'(MAX_BYTES)) ?
                      CmpW'(MAX_BYTES) : CmpW'(packet_limit_q);
  assign at_limit   = CmpW'(wr_off_q) >= limit_eff;
  assign queue_full = count_q >= CntW'(SLOTS);
  assign pop_last   = ((OffW+1)'(rd_off_q) + (OffW+1)'(1)) >= (OffW+1)'(meta_len_rdata_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dopq_pkg::StIdle: begin
        if (accept && cmd_i.command == dopq_pkg::CmdPop && count_q != '0) begin
          state_d = dopq_pkg::StPopRead;
        end
      end
      dopq_pkg::StPopRead: begin
        state_d = dopq_pkg::StIdle;
      end
      default: state_d = dopq_pkg::StIdle;
    endcase
  end

  // State outputs.
  always_comb begin
    busy = 1'b0;
    unique case (state_q)
      dopq_pkg::StIdle:    busy = 1'b0;
      dopq_pkg::StPopRead: busy = 1'b1;
      default:             busy = 1'b0;
    endcase
  end

  // Datapath: pointer updates, memory accesses and the result.
  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    wr_off_d   = wr_off_q;
    rd_off_d   = rd_off_q;
    overlong_d = overlong_q;
    done_d     = 1'b0;
    rsp_d      = rsp_q;
    byte_we    = 1'b0;
    byte_re    = 1'b0;
    meta_we    = 1'b0;
    meta_re    = 1'b0;
    byte_addr  = AddrW'(head_q) * AddrW'(MAX_BYTES) + AddrW'(rd_off_q);
    meta_addr  = head_q;

    if (state_q == dopq_pkg::StPopRead) begin
      done_d          = 1'b1;
      rsp_d.status    = dopq_pkg::StsPopped;
      rsp_d.out_byte  = byte_rdata_q;
      rsp_d.out_stamp = meta_stamp_rdata_q;
      rsp_d.out_key   = meta_key_rdata_q;
      rsp_d.out_last  = pop_last;
      if (pop_last) begin
        rd_off_d = '0;
        head_d   = next_slot(head_q);
        count_d  = count_q - CntW'(1);
      end else begin
        rd_off_d = rd_off_q + RdW'(1);
      end
    end else if (accept) begin
      done_d          = 1'b1;
      rsp_d.out_byte  = '0;
      rsp_d.out_last  = 1'b0;
      rsp_d.out_stamp = '0;
      rsp_d.out_key   = 1'b0;
      if (cmd_i.command == dopq_pkg::CmdPush) begin
        rsp_d.status = dopq_pkg::StsByteTaken;
        if (overlong_q || at_limit) begin
          // Bytes past the limit are dropped until the packet ends.
          if (cmd_i.last_byte) begin
            overlong_d   = 1'b0;
            wr_off_d     = '0;
            rsp_d.status = dopq_pkg::StsTooLong;
          end else begin
            overlong_d = 1'b1;
          end
        end else begin
          byte_we   = 1'b1;
          byte_addr = AddrW'(tail_q) * AddrW'(MAX_BYTES) + AddrW'(wr_off_q);
          wr_off_d  = wr_off_q + OffW'(1);
          if (cmd_i.last_byte) begin
            meta_we   = 1'b1;
            meta_addr = tail_q;
            wr_off_d  = '0;
            tail_d    = next_slot(tail_q);
            if (queue_full) begin
              head_d       = next_slot(head_q);
              rd_off_d     = '0;
              count_d      = CntW'(SLOTS);
              rsp_d.status = dopq_pkg::StsCommitDrop;
            end else begin
              count_d      = count_q + CntW'(1);
              rsp_d.status = dopq_pkg::StsCommitted;
            end
          end
        end
      end else if (count_q == '0) begin
        rsp_d.status = dopq_pkg::StsEmpty;
      end else begin
        // The result is formed next cycle from the registered read data.
        done_d  = 1'b0;
        byte_re = 1'b1;
        meta_re = 1'b1;
      end
    end
    rsp_d.queued = dopq_pkg::QueuedW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= dopq_pkg::StIdle;
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
      wr_off_q   <= '0;
      rd_off_q   <= '0;
      overlong_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      count_q    <= count_d;
      wr_off_q   <= wr_off_d;
      rd_off_q   <= rd_off_d;
      overlong_q <= overlong_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // The queue never holds more than SLOTS packets.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(SLOTS))
    else $error("packet count above SLOTS");

  // With nothing queued the read and write slots coincide.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (head_q == tail_q))
    else $error("empty queue with head and tail apart");

  // The read stage is always followed directly by idle and a popped byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (!busy && done_o && rsp_o.status == dopq_pkg::StsPopped))
    else $error("pop read stage did not deliver a byte");

  // A push transfer yields its result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i.command == dopq_pkg::CmdPush) |=> done_o)
    else $error("push without a result");

  // A pop on a non-empty queue always goes through the read stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i.command == dopq_pkg::CmdPop && count_q != '0) |=> (busy && !done_o))
    else $error("pop skipped the memory read");

endmodule

/* dv/tb_drop_oldest_packet_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drop-oldest packet queue testbench
// Drives push and pop commands through the start/busy port. An in-bench
// model of the queue predicts every response, which is checked field by
// field. Phases run at several packet limits written over APB.
// ----------------------------------------------------------------------------
module tb_drop_oldest_packet_queue;
  import dopq_pkg::*;

  localparam int Slots     = SlotsDefault;
  localparam int MaxBytes  = MaxBytesDefault;
  localparam int PhysSlots = Slots + 1;
  localparam int StallLimit = 3000;
  localparam logic [2:0] AddrLimit  = 3'd0;
  localparam logic [2:0] AddrUnused = 3'd4;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  cmd_t        cmd_i = '0;
  logic        done_o;
  rsp_t        rsp_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  drop_oldest_packet_queue DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .cmd_i   (cmd_i),
    .done_o  (done_o),
    .rsp_o   (rsp_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Commands waiting to be sent and responses waiting to arrive.
  cmd_t cmd_backlog[$];
  rsp_t awaited_rsps[$];

  int send_idle_pct = 30;
  int err_count = 0;
  int cmds_taken = 0;
  int pushes_taken = 0;
  int status_seen[6];
  int idle_cycles = 0;

  // Shadow copy of the queue contents and pointers.
  logic [7:0]        byte_mem [PhysSlots*MaxBytes];
  logic [12:0]       len_mem [PhysSlots];
  logic [StampW-1:0] stamp_mem [PhysSlots];
  logic              key_mem [PhysSlots];
  logic [3:0]        head_q = '0;
  logic [3:0]        tail_q = '0;
  logic [3:0]        count_q = '0;
  logic [12:0]       wr_off_q = '0;
  logic [11:0]       rd_off_q = '0;
  logic              overlong_q = 1'b0;
  logic [LimitW-1:0] cfg_limit = LimitReset;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [3:0] slot_after(logic [3:0] s);
    return (int'(s) + 1 >= PhysSlots) ? 4'd0 : s + 4'd1;
  endfunction

  // Applies one command to the shadow queue and returns its response.
  function automatic rsp_t next_response(cmd_t c);
    rsp_t r;
    int   lim;
    int   off;
    r = '0;
    if (c.command == CmdPush) begin
      lim = (int'(cfg_limit) > MaxBytes) ? MaxBytes : int'(cfg_limit);
      if (!overlong_q && int'(wr_off_q) + 1 > lim) overlong_q = 1'b1;
      if (overlong_q) begin
        // Bytes past the limit are dropped until the packet ends.
        if (c.last_byte) begin
          overlong_q = 1'b0;
          wr_off_q = '0;
          r.status = StsTooLong;
        end else begin
          r.status = StsByteTaken;
        end
      end else begin
        byte_mem[int'(tail_q)*MaxBytes + int'(wr_off_q)] = c.data_byte;
        wr_off_q = wr_off_q + 13'd1;
        if (c.last_byte) begin
          len_mem[tail_q] = wr_off_q;
          stamp_mem[tail_q] = c.stamp;
          key_mem[tail_q] = c.key_frame;
          wr_off_q = '0;
          tail_q = slot_after(tail_q);
          if (int'(count_q) >= Slots) begin
            head_q = slot_after(head_q);
            rd_off_q = '0;
            count_q = 4'(Slots);
            r.status = StsCommitDrop;
          end else begin
            count_q = count_q + 4'd1;
            r.status = StsCommitted;
          end
        end else begin
          r.status = StsByteTaken;
        end
      end
    end else if (count_q == 0) begin
      r.status = StsEmpty;
    end else begin
      off = int'(rd_off_q);
      r.status = StsPopped;
      r.out_byte = byte_mem[int'(head_q)*MaxBytes + off];
      r.out_stamp = stamp_mem[head_q];
      r.out_key = key_mem[head_q];
      if (off + 1 >= int'(len_mem[head_q])) begin
        r.out_last = 1'b1;
        rd_off_q = '0;
        head_q = slot_after(head_q);
        count_q = count_q - 4'd1;
      end else begin
        rd_off_q = 12'(off + 1);
      end
    end
    r.queued = count_q;
    return r;
  endfunction

  function automatic cmd_t make_cmd(cmd_e op, logic [7:0] data, logic last,
                                    logic [StampW-1:0] stamp, logic key);
    cmd_t c;
    c.command = op;
    c.data_byte = data;
    c.last_byte = last;
    c.stamp = stamp;
    c.key_frame = key;
    return c;
  endfunction

  function automatic cmd_t random_cmd(cmd_e op, logic last);
    return make_cmd(op, 8'($urandom), last, {$urandom, $urandom}, 1'($urandom));
  endfunction

  // Driver: a command stays on the port until the transfer completes.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        awaited_rsps.push_back(next_response(cmd_i));
        cmds_taken++;
        if (cmd_i.command == CmdPush) pushes_taken++;
      end
      if (start && busy) begin
        // Hold the current command.
      end else if (cmd_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        start <= 1'b1;
        cmd_i <= cmd_backlog.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // Monitor and watchdog.
  always @(posedge clk_i) begin
    rsp_t exp_r;
    if (rst_ni) begin
      if (done_o) begin
        if (awaited_rsps.size() == 0) begin
          err_count++;
          $display("%0t: unexpected response, expected none, actual %0h", $time, rsp_o);
        end else begin
          exp_r = awaited_rsps.pop_front();
          check_field("status", exp_r.status, rsp_o.status);
          check_field("out_byte", exp_r.out_byte, rsp_o.out_byte);
          check_field("out_last", exp_r.out_last, rsp_o.out_last);
          check_field("out_stamp", exp_r.out_stamp, rsp_o.out_stamp);
          check_field("out_key", exp_r.out_key, rsp_o.out_key);
          check_field("queued", exp_r.queued, rsp_o.queued);
          if (int'(rsp_o.status) < 6) status_seen[rsp_o.status]++;
        end
      end
      if (done_o || (start && !busy)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, StallLimit);
        $display("drop_oldest_packet_queue regression: fail");
        $finish;
      end
    end
  end

  task automatic apb_access(input logic wr, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] wdata);
    logic [31:0] unused;
    apb_access(1'b1, addr, wdata, unused);
    if (addr >> 2 == RegPacketLimit) cfg_limit = wdata[LimitW-1:0];
  endtask

  task automatic check_limit_readback();
    logic [31:0] rdata;
    apb_access(1'b0, AddrLimit, '0, rdata);
    if (rdata !== 32'(cfg_limit)) begin
      err_count++;
      $display("%0t: packet_limit readback, expected %0h, actual %0h",
               $time, cfg_limit, rdata);
    end
  endtask

  // Waits until every queued command has been answered and start is low.
  task automatic drain();
    @(posedge clk_i);
    while (start || cmd_backlog.size() > 0 || awaited_rsps.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic add_pops(int n);
    repeat (n) cmd_backlog.push_back(random_cmd(CmdPop, 1'($urandom)));
  endtask

  task automatic add_packet(int len);
    for (int i = 1; i <= len; i++) cmd_backlog.push_back(random_cmd(CmdPush, i == len));
  endtask

  // Pushes and pops interleaved; the pop share is redrawn every hundred
  // commands so the queue alternates between overflowing and draining.
  task automatic random_traffic(int n_items, int max_len);
    int left;
    int pop_pct;
    left = 0;
    pop_pct = 40;
    for (int i = 0; i < n_items; i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: pop_pct = 15;
          1: pop_pct = 45;
          default: pop_pct = 75;
        endcase
      end
      if ($urandom_range(0, 99) < pop_pct) begin
        add_pops(1);
      end else begin
        if (left == 0) begin
          left = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 3*max_len)
                                              : $urandom_range(1, max_len);
        end
        cmd_backlog.push_back(random_cmd(CmdPush, left == 1));
        left--;
      end
    end
    while (left > 0) begin
      cmd_backlog.push_back(random_cmd(CmdPush, left == 1));
      left--;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty pop, field extremes, overflow, and dropping a partly
    // read head packet.
    check_limit_readback();
    cmd_backlog.push_back(make_cmd(CmdPop, 8'h00, 1'b0, '0, 1'b0));
    cmd_backlog.push_back(make_cmd(CmdPush, 8'hFF, 1'b1, '1, 1'b1));
    cmd_backlog.push_back(make_cmd(CmdPush, 8'h00, 1'b0, '1, 1'b1));
    cmd_backlog.push_back(make_cmd(CmdPush, 8'h00, 1'b1, '0, 1'b0));
    add_pops(4);
    add_packet(3);
    repeat (7) add_packet(1);
    add_pops(1);
    add_packet(1);
    add_pops(1);
    random_traffic(500, 12);
    drain();

    // Small limit, with the upper data bits set to show they are dropped.
    reg_write(AddrLimit, 32'hFFFF_E005);
    check_limit_readback();
    random_traffic(350, 8);
    drain();

    send_idle_pct = 73;
    reg_write(AddrLimit, 32'h0000_0000);
    check_limit_readback();
    random_traffic(100, 3);
    drain();

    reg_write(AddrLimit, 32'h0000_0001);
    check_limit_readback();
    random_traffic(300, 3);
    drain();

    // Limit above storage size, with commands back to back.
    send_idle_pct = 0;
    reg_write(AddrLimit, 32'h0000_1FFF);
    check_limit_readback();
    random_traffic(350, 12);
    drain();

    // Writes to other addresses must leave the limit alone.
    reg_write(AddrUnused, $urandom);
    check_limit_readback();
    reg_write(AddrLimit, 32'(LimitReset));
    check_limit_readback();
    random_traffic(400, 16);
    drain();

    $display("Sent %0d commands (%0d pushes, %0d pops) across six packet limits.",
             cmds_taken, pushes_taken, cmds_taken - pushes_taken);
    $display("Responses: %0d committed, %0d dropped oldest, %0d too long, %0d popped, %0d empty.",
             status_seen[StsCommitted], status_seen[StsCommitDrop], status_seen[StsTooLong],
             status_seen[StsPopped], status_seen[StsEmpty]);
    if (err_count == 0) begin
      $display("drop_oldest_packet_queue regression: pass");
    end else begin
      $display("drop_oldest_packet_queue regression: fail");
    end
    $finish;
  end

endmodule
